// File: sv/sraf_pkg.sv
package sraf_pkg;

	// Default geometry of the sample store
	localparam int RING_DEPTH_DEF   = 20;
	localparam int NUM_CHANNELS_DEF = 4;

	// Byte that marks an empty ring entry, and the largest byte that counts as data
	localparam logic [7:0] EMPTY_MARK = 8'hFF;
	localparam int         MAX_STORED = 254;

	localparam int         VAL_W           = 8;
	localparam logic [7:0] NOISE_RESET     = 8'd50;
	localparam int         MAX_REPORTED    = 4;

	localparam logic OP_SAMPLE  = 1'b0;
	localparam logic OP_REFRESH = 1'b1;

	typedef logic [7:0] cfg_word_t;

	typedef struct packed {
		logic       op;
		logic [1:0] channel;
		logic [7:0] sample;
	} req_item_t;

	typedef struct packed {
		logic [1:0] out_channel;
		logic [7:0] value;
		logic       accepted;
		logic       has_data;
		logic       last;
	} rsp_item_t;

endpackage

// File: sv/sraf_stream_if.sv
interface sraf_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: sv/spike_rejecting_average_filter_top.sv
// Spike-rejecting moving average over several sensor channels.
// Channels (valid/ready, an item moves when both are high at a rising clk edge):
//   req : input items of type req_item_t. op = OP_SAMPLE stores one sample byte
//         for a channel, op = OP_REFRESH recomputes the averages of all channels.
//   rsp : result items of type rsp_item_t. A sample item gives one result,
//         a refresh item gives one result per reported channel (up to four),
//         in channel order, with last set on the final one.
//   cfg : write of the noise threshold (one byte), always ready. Write it only
//         while no item is in flight.
// Timing: one item is worked on at a time; req is ready only while idle.
//   A sample item reads the previous entry at accept, then compares and writes
//   back in ST_S_CMP and loads the result register in ST_S_EMIT.
//   A refresh item walks the ring memory one entry a cycle and runs an 8-step
//   restoring divider per channel.
// Reset: arst_n clears the per-entry valid bits, so every ring entry reads as
//   empty at once; write slots and averages go to zero, threshold to 50.
// Stall: a finished result waits in the output register; the block holds the
//   next result (and stays busy) until rsp takes the pending item.
module spike_rejecting_average_filter_top #(
	parameter int RING_DEPTH   = sraf_pkg::RING_DEPTH_DEF,
	parameter int NUM_CHANNELS = sraf_pkg::NUM_CHANNELS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	sraf_stream_if.sink   req,
	sraf_stream_if.source rsp,
	sraf_stream_if.sink   cfg
);
	import sraf_pkg::*;

	localparam int DEPTH    = NUM_CHANNELS * RING_DEPTH;
	localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW       = $clog2(RING_DEPTH);
	localparam int JW       = $clog2(RING_DEPTH + 1);
	localparam int CW       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int REPORTED = (NUM_CHANNELS < MAX_REPORTED) ? NUM_CHANNELS : MAX_REPORTED;
	localparam int SUMW     = $clog2(RING_DEPTH * MAX_STORED + 1);
	localparam int NW       = SUMW + 2;
	localparam int DW       = JW + 1;
	localparam int DCW      = $clog2(VAL_W);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_S_CMP  = 6'b000010,
		ST_S_EMIT = 6'b000100,
		ST_R_SCAN = 6'b001000,
		ST_R_DIV  = 6'b010000,
		ST_R_EMIT = 6'b100000
	} state_t;

	state_t state_q;

	// Ring memory and its per-entry valid bits
	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [7:0]       rd_s1;
	logic             vld_s1;
	logic [AW-1:0]    rd_addr;
	logic             mem_we;

	// Per-channel state
	logic [SW-1:0] write_slot_q [NUM_CHANNELS];
	logic [7:0]    avg_q        [NUM_CHANNELS];
	cfg_word_t     noise_q;

	// Sample item context
	logic [1:0]    ch_q;
	logic [7:0]    smp_q;
	logic [CW-1:0] chidx_q;
	logic [AW-1:0] wr_addr_q;
	logic [SW-1:0] slot_nxt_q;
	logic          take_q;

	// Refresh context
	logic [1:0]       k_q;
	logic [JW-1:0]    j_q;
	logic [AW-1:0]    scan_addr_q;
	logic             pend_s1;
	logic [SUMW-1:0]  sum_q;
	logic [JW-1:0]    cnt_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    d_q;
	logic [VAL_W-1:0] nlo_q;
	logic [VAL_W-1:0] quo_q;
	logic [DCW-1:0]   divc_q;
	logic             has_q;

	// Output register
	logic      out_valid_q;
	rsp_item_t out_q;
	logic      out_free;
	logic      emit;

	// Decode of the offered item
	logic [2:0]    ch3;
	logic          ch_ok;
	logic [CW-1:0] chidx;
	logic [SW-1:0] slot_cur;
	logic [SW-1:0] prev_slot;
	logic [AW-1:0] base;

	// Datapath helpers
	logic [7:0]    pv;
	logic [7:0]    diff;
	logic          take;
	logic [7:0]    scan_val;
	logic [NW-1:0] numer;
	logic [DW:0]   trial;
	logic          ge;
	logic [2:0]    k3;
	logic [CW-1:0] kidx;
	logic          k_last;

	assign ch3       = {1'b0, req.data.channel};
	assign ch_ok     = {29'd0, ch3} < 32'(NUM_CHANNELS);
	assign chidx     = ch3[CW-1:0];
	assign slot_cur  = write_slot_q[chidx];
	assign prev_slot = (slot_cur == '0) ? SW'(RING_DEPTH - 1) : slot_cur - 1'b1;
	assign base      = AW'(chidx) * AW'(RING_DEPTH);

	assign pv   = vld_s1 ? rd_s1 : EMPTY_MARK;
	assign diff = (smp_q >= pv) ? smp_q - pv : pv - smp_q;
	assign take = (pv == EMPTY_MARK) || (diff < noise_q);

	assign scan_val = vld_s1 ? rd_s1 : EMPTY_MARK;
	assign numer    = NW'({sum_q, 1'b0}) + NW'(cnt_q);

	assign trial = {rem_q, nlo_q[VAL_W-1]};
	assign ge    = trial >= {1'b0, d_q};

	assign k3     = {1'b0, k_q};
	assign kidx   = k3[CW-1:0];
	assign k_last = k_q == 2'(REPORTED - 1);

	assign out_free = !out_valid_q || rsp.ready;
	assign emit     = ((state_q == ST_S_EMIT) || (state_q == ST_R_EMIT)) && out_free;

	assign req.ready = state_q == ST_IDLE;
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// Read the previous entry at accept; walk the ring during refresh
	assign rd_addr = (state_q == ST_IDLE) ? base + AW'(prev_slot) : scan_addr_q;
	assign mem_we  = (state_q == ST_S_CMP) && take;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr_q] <= smp_q;
		end
		rd_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vld_q       <= '0;
			vld_s1      <= 1'b0;
			noise_q     <= NOISE_RESET;
			out_valid_q <= 1'b0;
			pend_s1     <= 1'b0;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				write_slot_q[c] <= '0;
				avg_q[c]        <= '0;
			end
		end else begin
			vld_s1 <= vld_q[rd_addr];

			if (cfg.valid) begin
				noise_q <= cfg.data;
			end

			// load a new result, or drop the one the receiver takes
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						ch_q       <= req.data.channel;
						smp_q      <= req.data.sample;
						chidx_q    <= chidx;
						wr_addr_q  <= base + AW'(slot_cur);
						slot_nxt_q <= (slot_cur == SW'(RING_DEPTH - 1)) ? '0 : slot_cur + 1'b1;
						if (req.data.op == OP_REFRESH) begin
							k_q         <= '0;
							j_q         <= '0;
							scan_addr_q <= '0;
							pend_s1     <= 1'b0;
							sum_q       <= '0;
							cnt_q       <= '0;
							state_q     <= ST_R_SCAN;
						end else if (ch_ok) begin
							state_q <= ST_S_CMP;
						end else begin
							// channel not present: answer without touching state
							take_q  <= 1'b0;
							state_q <= ST_S_EMIT;
						end
					end
				end
				ST_S_CMP: begin
					if (take) begin
						vld_q[wr_addr_q] <= 1'b1;
					end
					write_slot_q[chidx_q] <= slot_nxt_q;
					take_q                <= take;
					state_q               <= ST_S_EMIT;
				end
				ST_S_EMIT: begin
					if (out_free) begin
						out_q.out_channel <= ch_q;
						out_q.value       <= smp_q;
						out_q.accepted    <= take_q;
						out_q.has_data    <= 1'b0;
						out_q.last        <= 1'b1;
						state_q           <= ST_IDLE;
					end
				end
				ST_R_SCAN: begin
					// accumulate the entry read last cycle
					if (pend_s1 && (scan_val != EMPTY_MARK)) begin
						sum_q <= sum_q + SUMW'(scan_val);
						cnt_q <= cnt_q + 1'b1;
					end
					if (j_q != JW'(RING_DEPTH)) begin
						j_q         <= j_q + 1'b1;
						scan_addr_q <= scan_addr_q + 1'b1;
						pend_s1     <= 1'b1;
					end else begin
						pend_s1 <= 1'b0;
						if (!pend_s1) begin
							// numerator 2*sum+cnt over 2*cnt; quotient fits 8 bits
							rem_q   <= DW'(numer >> VAL_W);
							nlo_q   <= numer[VAL_W-1:0];
							d_q     <= {cnt_q, 1'b0};
							divc_q  <= '0;
							has_q   <= cnt_q != '0;
							state_q <= ST_R_DIV;
						end
					end
				end
				ST_R_DIV: begin
					rem_q  <= ge ? DW'(trial - {1'b0, d_q}) : DW'(trial);
					quo_q  <= {quo_q[VAL_W-2:0], ge};
					nlo_q  <= {nlo_q[VAL_W-2:0], 1'b0};
					divc_q <= divc_q + 1'b1;
					if (divc_q == DCW'(VAL_W - 1)) begin
						state_q <= ST_R_EMIT;
					end
				end
				ST_R_EMIT: begin
					if (out_free) begin
						if (has_q) begin
							avg_q[kidx] <= quo_q;
						end
						out_q.out_channel <= k_q;
						out_q.value       <= has_q ? quo_q : avg_q[kidx];
						out_q.accepted    <= 1'b0;
						out_q.has_data    <= has_q;
						out_q.last        <= k_last;
						if (k_last) begin
							state_q <= ST_IDLE;
						end else begin
							// advance to the next channel; scan address runs on
							k_q     <= k_q + 1'b1;
							j_q     <= '0;
							sum_q   <= '0;
							cnt_q   <= '0;
							state_q <= ST_R_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: verif/tb_top.sv
// Tracks the filter state and holds the results that the block still owes.
class spike_filter_tracker;
	logic [7:0] ring [sraf_pkg::NUM_CHANNELS_DEF][sraf_pkg::RING_DEPTH_DEF];
	int unsigned next_slot [sraf_pkg::NUM_CHANNELS_DEF];
	logic [7:0] last_avg [sraf_pkg::NUM_CHANNELS_DEF];
	logic [7:0] noise_limit;
	sraf_pkg::rsp_item_t pending_reports [$];
	int unsigned fail_count;

	function new();
		for (int c = 0; c < sraf_pkg::NUM_CHANNELS_DEF; c++) begin
			for (int s = 0; s < sraf_pkg::RING_DEPTH_DEF; s++)
				ring[c][s] = sraf_pkg::EMPTY_MARK;
			next_slot[c] = 0;
			last_avg[c] = '0;
		end
		noise_limit = sraf_pkg::NOISE_RESET;
		fail_count = 0;
	endfunction

	function void set_threshold(input logic [7:0] v);
		noise_limit = v;
	endfunction

	// Work out the results of one accepted item and queue them.
	function void note_item(input sraf_pkg::req_item_t item);
		sraf_pkg::rsp_item_t rep;
		int unsigned ch, slot, prev, prev_val, diff, sum, cnt;
		int reported;
		reported = (sraf_pkg::NUM_CHANNELS_DEF < sraf_pkg::MAX_REPORTED) ?
			sraf_pkg::NUM_CHANNELS_DEF : sraf_pkg::MAX_REPORTED;
		rep = '0;
		if (item.op == sraf_pkg::OP_SAMPLE) begin
			ch = item.channel;
			rep.out_channel = item.channel;
			rep.value = item.sample;
			rep.last = 1'b1;
			if (ch < sraf_pkg::NUM_CHANNELS_DEF) begin
				slot = next_slot[ch];
				if (slot >= sraf_pkg::RING_DEPTH_DEF)
					slot = 0;
				// slot 0 looks back at the last slot of the ring
				prev = (slot == 0) ? sraf_pkg::RING_DEPTH_DEF - 1 : slot - 1;
				prev_val = ring[ch][prev];
				diff = (item.sample >= prev_val) ? item.sample - prev_val :
					prev_val - item.sample;
				rep.accepted = (ring[ch][prev] == sraf_pkg::EMPTY_MARK) ||
					(diff < noise_limit);
				if (rep.accepted)
					ring[ch][slot] = item.sample;
				next_slot[ch] = (slot + 1 >= sraf_pkg::RING_DEPTH_DEF) ? 0 : slot + 1;
			end
			pending_reports.push_back(rep);
		end else begin
			for (int k = 0; k < reported; k++) begin
				sum = 0;
				cnt = 0;
				for (int s = 0; s < sraf_pkg::RING_DEPTH_DEF; s++) begin
					if (ring[k][s] != sraf_pkg::EMPTY_MARK) begin
						sum += ring[k][s];
						cnt++;
					end
				end
				// round half up; an empty channel keeps its old average
				if (cnt > 0)
					last_avg[k] = 8'((2 * sum + cnt) / (2 * cnt));
				rep.out_channel = 2'(k);
				rep.value = last_avg[k];
				rep.accepted = 1'b0;
				rep.has_data = (cnt > 0);
				rep.last = (k == reported - 1);
				pending_reports.push_back(rep);
			end
		end
	endfunction

	function void compare_field(input string what, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			fail_count++;
		end
	endfunction

	function void check_report(input sraf_pkg::rsp_item_t got);
		sraf_pkg::rsp_item_t want;
		if (pending_reports.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual channel %0d value %0d",
				$time, got.out_channel, got.value);
			fail_count++;
			return;
		end
		want = pending_reports.pop_front();
		compare_field("out_channel", want.out_channel, got.out_channel);
		compare_field("value", want.value, got.value);
		compare_field("accepted", want.accepted, got.accepted);
		compare_field("has_data", want.has_data, got.has_data);
		compare_field("last", want.last, got.last);
	endfunction
endclass

module tb_top;
	import sraf_pkg::*;

	localparam int CHANNELS = NUM_CHANNELS_DEF;

	logic clk = 1'b0;
	logic arst_n;

	sraf_stream_if #(.payload_t(req_item_t)) req_if ();
	sraf_stream_if #(.payload_t(rsp_item_t)) rsp_if ();
	sraf_stream_if #(.payload_t(cfg_word_t)) cfg_if ();

	spike_filter_tracker sb;

	// Stimulus state: a random walk per channel keeps most samples inside the
	// noise band so that the rings fill up and wrap.
	logic [7:0] walk_val [CHANNELS];
	int burst_left;
	bit sender_gaps = 1'b0;
	bit receiver_stalls = 1'b0;

	spike_rejecting_average_filter_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	always #5 clk = ~clk;

	// Observe all three channels at the rising edge. Results go first so that
	// the queue order never depends on process scheduling.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready)
				sb.check_report(rsp_if.data);
			if (cfg_if.valid && cfg_if.ready)
				sb.set_threshold(cfg_if.data);
			if (req_if.valid && req_if.ready)
				sb.note_item(req_if.data);
		end
	end

	// Receiver: stall in short random runs while stalls are enabled.
	initial begin
		int stall_left;
		stall_left = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (receiver_stalls && stall_left == 0 && $urandom_range(0, 3) == 0)
				stall_left = $urandom_range(1, 8);
			if (stall_left > 0) begin
				rsp_if.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		#4000000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic req_item_t make_item(input logic op, input logic [1:0] ch,
		input logic [7:0] smp);
		req_item_t item;
		item.op = op;
		item.channel = ch;
		item.sample = smp;
		return item;
	endfunction

	function automatic req_item_t random_item();
		req_item_t item;
		int roll, span, v;
		item.op = OP_SAMPLE;
		item.channel = 2'($urandom);
		item.sample = 8'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			// refresh; channel and sample stay random noise
			item.op = OP_REFRESH;
		end else if (roll < 70) begin
			// step within the noise band so most samples get stored
			span = (sb.noise_limit < 4) ? 4 : int'(sb.noise_limit);
			v = int'(walk_val[item.channel]) + int'($urandom_range(0, 2 * span)) - span;
			if (v < 0)
				v = 0;
			if (v > MAX_STORED)
				v = MAX_STORED;
			walk_val[item.channel] = 8'(v);
			item.sample = 8'(v);
		end else if (roll < 78) begin
			item.sample = EMPTY_MARK;
		end else if (roll < 88) begin
			// spike far from the running level
			item.sample = walk_val[item.channel] ^ 8'h80;
		end
		return item;
	endfunction

	// Present one item and hold it until accepted. Insert a gap between bursts while gaps are enabled.
	task automatic send_item(input req_item_t item);
		if (burst_left == 0) begin
			if (sender_gaps) begin
				req_if.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		req_if.valid <= 1'b1;
		req_if.data <= item;
		do @(posedge clk); while (!req_if.ready);
		@(negedge clk);
	endtask

	// Drop valid and wait until every owed result has arrived.
	task automatic settle();
		req_if.valid <= 1'b0;
		while (sb.pending_reports.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
		burst_left = 0;
	endtask

	// Write the threshold only with the block idle.
	task automatic write_threshold(input cfg_word_t v);
		settle();
		cfg_if.valid <= 1'b1;
		cfg_if.data <= v;
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	initial begin
		req_item_t directed [$];
		cfg_word_t phase_limit [5];

		sb = new();
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		burst_left = 0;
		for (int c = 0; c < CHANNELS; c++)
			walk_val[c] = 8'd100;

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset threshold of 50.
		directed = '{
			make_item(OP_REFRESH, 2'd0, 8'd0),   // refresh with every ring empty
			make_item(OP_SAMPLE, 2'd0, 8'd0),    // previous entry empty: store
			make_item(OP_SAMPLE, 2'd0, 8'd49),   // just inside the band
			make_item(OP_SAMPLE, 2'd0, 8'd100),  // just outside: reject
			make_item(OP_SAMPLE, 2'd0, 8'd200),  // previous entry empty again
			make_item(OP_SAMPLE, 2'd0, 8'd150),  // difference equal to threshold
			make_item(OP_SAMPLE, 2'd1, 8'd255),  // marker byte stored as empty
			make_item(OP_SAMPLE, 2'd1, 8'd10),   // previous reads as empty
			make_item(OP_SAMPLE, 2'd2, 8'd1),
			make_item(OP_SAMPLE, 2'd2, 8'd2),    // average 1.5 rounds up
			make_item(OP_SAMPLE, 2'd3, 8'd254),
			make_item(OP_SAMPLE, 2'd3, 8'd254),
			make_item(OP_SAMPLE, 2'd3, 8'd0),    // widest spike
			make_item(OP_REFRESH, 2'd3, 8'd255),
			make_item(OP_SAMPLE, 2'd1, 8'd255),  // marker as a spike
			make_item(OP_SAMPLE, 2'd1, 8'd11),
			make_item(OP_SAMPLE, 2'd2, 8'd255),
			make_item(OP_SAMPLE, 2'd3, 8'd128),
			make_item(OP_REFRESH, 2'd1, 8'd127)
		};
		sender_gaps = 1'b1;
		receiver_stalls = 1'b1;
		foreach (directed[i])
			send_item(directed[i]);

		// Random phases: both extremes, the tightest band, a random one, reset value.
		phase_limit[0] = 8'd255;
		phase_limit[1] = 8'd0;
		phase_limit[2] = 8'd1;
		phase_limit[3] = 8'($urandom_range(2, 254));
		phase_limit[4] = NOISE_RESET;
		for (int p = 0; p < 5; p++) begin
			write_threshold(phase_limit[p]);
			// run one phase with a steady sender, another with a steady receiver
			sender_gaps = (p != 1);
			receiver_stalls = (p != 3);
			for (int i = 0; i < 44; i++) begin
				// hold the sender mid-phase until the block has drained
				if (p == 2 && i == 22)
					settle();
				send_item(random_item());
			end
		end

		settle();
		// catch any stray result a refresh might still produce
		repeat (150) @(negedge clk);
		if (sb.pending_reports.size() != 0) begin
			$display("%0t: results outstanding, expected 0, actual %0d", $time,
				sb.pending_reports.size());
			sb.fail_count++;
		end
		if (sb.fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

// File: sim.f
sv/sraf_pkg.sv
sv/sraf_stream_if.sv
sv/spike_rejecting_average_filter_top.sv
verif/tb_top.sv
